### rtl/ssidm_pkg.sv
// ----------------------------------------------------------------------------
// ssidm_pkg
// Shared types and constants for the sorted set insert/delete/member unit.
// ----------------------------------------------------------------------------
package ssidm_pkg;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned IN_KEY_W   = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_DATA_W = ((STAT_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - STAT_W - CNT_W;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_MISS = 2'd0,
    STAT_HIT  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

  function automatic key_t to_key(input logic [IN_KEY_W-1:0] raw);
    logic signed [IN_KEY_W-1:0] sraw;
    sraw = $signed(raw);
    return key_t'(sraw);
  endfunction

endpackage

### rtl/ssidm_cell.sv
// ----------------------------------------------------------------------------
// ssidm_cell
// One slot of the sorted store: holds a key, compares it against the search
// key and shifts in from a neighbor on insert or delete.
// ----------------------------------------------------------------------------
module ssidm_cell
  import ssidm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cnt_t       idx_i,
  input  cnt_t       count_i,
  input  key_t       key_i,
  input  key_t       left_key_i,
  input  logic       left_lt_i,
  input  key_t       right_key_i,
  output key_t       key_o,
  output logic       lt_o,
  output logic       eq_o
);

  key_t key_q, key_d;
  logic lt_q, eq_q;
  logic valid;

  assign valid = (idx_i < count_i);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && !lt_q) begin
      key_d = left_lt_i ? key_i : left_key_i;
    end else if (ctrl_i.del && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      lt_q <= valid && (key_q < key_i);
      eq_q <= valid && (key_q == key_i);
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

### rtl/sorted_set_insert_delete_member_unit.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_delete_member_unit
// Bounded sorted set of signed keys with query, insert and delete.
// ----------------------------------------------------------------------------
// Each transaction has a compare step and an update step: every cell compares
// its key with the request key when the request is accepted, and in ST_UPD the
// row of cells shifts up (insert) or down (delete) by one and the result is
// loaded into the output register. A new request is taken only in ST_IDLE, once
// the last one is through; a waiting result holds the shift step in ST_UPD.
module sorted_set_insert_delete_member_unit
  import ssidm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_KEY_W-1:0]   s_axis_tdata_i,  // [31:0] key
  input  logic [KIND_W-1:0]     s_axis_tuser_i,  // [1:0] kind
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // [1:0] status, [10:2] stored_count
);

  state_e     state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  kind_e      kind_q;
  key_t       key_q;
  key_t       bus_key;
  logic       out_vld_q, out_vld_d;
  status_e    out_stat_q, out_stat_d;
  cnt_t       out_cnt_q;
  cell_ctrl_t ctrl;
  logic       accept, hit, full, out_free;

  key_t              cell_key [CAPACITY];
  logic [CAPACITY-1:0] lt, eq;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign bus_key         = (state_q == ST_IDLE) ? to_key(s_axis_tdata_i) : key_q;
  assign hit             = |eq;
  assign full            = (cnt_q == cnt_t'(CAPACITY));
  assign out_free        = !out_vld_q || m_axis_tready_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t lkey, rkey;
    logic llt;
    if (i == 0) begin : g_first
      assign lkey = bus_key;
      assign llt  = 1'b1;
    end else begin : g_mid
      assign lkey = cell_key[i-1];
      assign llt  = lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rkey = cell_key[i];
    end else begin : g_nxt
      assign rkey = cell_key[i+1];
    end
    ssidm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .idx_i       (cnt_t'(i)),
      .count_i     (cnt_q),
      .key_i       (bus_key),
      .left_key_i  (lkey),
      .left_lt_i   (llt),
      .right_key_i (rkey),
      .key_o       (cell_key[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_stat_d = out_stat_q;
    ctrl       = '0;
    ctrl.cmp   = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          state_d   = ST_IDLE;
          out_vld_d = 1'b1;
          unique case (kind_q)
            KIND_INSERT: begin
              if (hit) begin
                out_stat_d = STAT_MISS;
              end else if (full) begin
                out_stat_d = STAT_FULL;
              end else begin
                ctrl.ins   = 1'b1;
                cnt_d      = cnt_q + cnt_t'(1);
                out_stat_d = STAT_HIT;
              end
            end
            KIND_DELETE: begin
              if (hit) begin
                ctrl.del   = 1'b1;
                cnt_d      = cnt_q - cnt_t'(1);
                out_stat_d = STAT_HIT;
              end else begin
                out_stat_d = STAT_MISS;
              end
            end
            default: begin
              out_stat_d = hit ? STAT_HIT : STAT_MISS;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(s_axis_tuser_i);
      key_q  <= to_key(s_axis_tdata_i);
    end
    if ((state_q == ST_UPD) && out_free) begin
      out_stat_q <= out_stat_d;
      out_cnt_q  <= cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_cnt_q, out_stat_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  a_eq_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(eq))
    else $error("more than one cell matches");

  a_ins_del_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete in same cycle");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins || ctrl.del) |=> $stable(cnt_q))
    else $error("count changed without shift");

  a_full_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_stat_q == STAT_FULL)) |-> (out_cnt_q == cnt_t'(CAPACITY)))
    else $error("full status while store not full");

endmodule
